FILE: src/moat_pkg.sv
// ----------------------------------------------------------------------------
// moat_pkg
// Shared types, codes and helpers for the message outbox ack tracker.
// ----------------------------------------------------------------------------
package moat_pkg;

  // Field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned IdW     = 8;
  localparam int unsigned StatW   = 2;
  localparam int unsigned NoticeW = 3;
  localparam int unsigned SleepW  = 7;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_OUTBOX_SIZE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT     = 1'b1;

  // Configuration reset values
  localparam logic [CfgW-1:0] MAX_OUTBOX_SIZE_RST = 16'd1024;
  localparam logic [CfgW-1:0] ACK_TIMEOUT_RST     = 16'd10000;

  // Backoff ceiling in ms
  localparam logic [SleepW-1:0] BACKOFF_CAP = 7'd100;

  typedef enum logic [OpW-1:0] {
    OP_OPEN      = 3'd0,
    OP_CLOSE     = 3'd1,
    OP_BEGIN     = 3'd2,
    OP_SEND      = 3'd3,
    OP_ACK_NACK  = 3'd4,
    OP_XPORT_DONE = 3'd5,
    OP_TICK      = 3'd6
  } opcode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_BUSY     = 2'd1,
    ST_INVALID  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [NoticeW-1:0] {
    NT_NONE     = 3'd0,
    NT_SENT     = 3'd1,
    NT_TIMEOUT  = 3'd2,
    NT_REJECTED = 3'd3,
    NT_NOCONN   = 3'd4
  } notice_e;

  typedef enum logic [1:0] {
    OC_OK       = 2'd0,
    OC_TIMEOUT  = 2'd1,
    OC_REJECTED = 2'd2,
    OC_NOCONN   = 2'd3
  } outcome_e;

  // Message phase, one-hot
  typedef enum logic [5:0] {
    PH_CLOSED = 6'b000001,
    PH_ACCEPT = 6'b000010,
    PH_WRITE  = 6'b000100,
    PH_BOTH   = 6'b001000,
    PH_REPLY  = 6'b010000,
    PH_XPORT  = 6'b100000
  } phase_e;

  // Encoded phase codes as seen on the result
  localparam logic [PhaseW-1:0] PC_CLOSED = 3'd0;
  localparam logic [PhaseW-1:0] PC_ACCEPT = 3'd1;
  localparam logic [PhaseW-1:0] PC_WRITE  = 3'd2;
  localparam logic [PhaseW-1:0] PC_BOTH   = 3'd3;
  localparam logic [PhaseW-1:0] PC_REPLY  = 3'd4;
  localparam logic [PhaseW-1:0] PC_XPORT  = 3'd5;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [SizeW-1:0] size_bytes;
    logic [IdW-1:0]   reply_id;
    logic             is_nack;
    logic             transport_ok;
  } item_t;

  typedef struct packed {
    status_e            status;
    notice_e            notice;
    logic [IdW-1:0]     message_id;
    logic [SleepW-1:0]  sleep_ms;
    logic [PhaseW-1:0]  phase_now;
  } result_t;

  typedef struct packed {
    phase_e             phase;
    logic [IdW-1:0]     txn_id;
    logic [SizeW-1:0]   size_limit;
    outcome_e           outcome;
    logic               timer_running;
    logic [TimerW-1:0]  timer_count;
    logic [SleepW-1:0]  backoff_ms;
  } state_t;

  typedef struct packed {
    logic [CfgW-1:0] max_outbox_size;
    logic [CfgW-1:0] ack_timeout_ticks;
  } cfg_t;

  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    unique case (ph)
      PH_CLOSED: code = PC_CLOSED;
      PH_ACCEPT: code = PC_ACCEPT;
      PH_WRITE:  code = PC_WRITE;
      PH_BOTH:   code = PC_BOTH;
      PH_REPLY:  code = PC_REPLY;
      PH_XPORT:  code = PC_XPORT;
      default:   code = PC_CLOSED;
    endcase
    return code;
  endfunction

  // Completion notice for a stored outcome
  function automatic notice_e finish_notice(outcome_e oc);
    return notice_e'(NoticeW'({1'b0, oc}) + NoticeW'(1));
  endfunction

endpackage

FILE: src/moat_step.sv
// ----------------------------------------------------------------------------
// moat_step
// Next-state and result logic for one event applied to the tracker state.
// ----------------------------------------------------------------------------
module moat_step (
  input  moat_pkg::state_t  st_i,
  input  moat_pkg::cfg_t    cfg_i,
  input  moat_pkg::item_t   item_i,
  output moat_pkg::state_t  st_o,
  output moat_pkg::result_t res_o
);
  import moat_pkg::*;

  logic [SleepW:0]   backoff_dbl;
  logic [SleepW-1:0] backoff_nxt;
  logic [SizeW-1:0]  grant;
  logic              pending;
  logic              awaits_reply;

  // Backoff: 1 ms first, then doubling up to the cap
  assign backoff_dbl = {st_i.backoff_ms, 1'b0};
  always_comb begin
    if (st_i.backoff_ms == '0) begin
      backoff_nxt = SleepW'(1);
    end else if (backoff_dbl > {1'b0, BACKOFF_CAP}) begin
      backoff_nxt = BACKOFF_CAP;
    end else begin
      backoff_nxt = backoff_dbl[SleepW-1:0];
    end
  end

  assign grant = (item_i.size_bytes > cfg_i.max_outbox_size) ?
                 cfg_i.max_outbox_size : item_i.size_bytes;
  assign pending      = (st_i.phase == PH_BOTH) || (st_i.phase == PH_REPLY) ||
                        (st_i.phase == PH_XPORT);
  assign awaits_reply = (st_i.phase == PH_BOTH) || (st_i.phase == PH_REPLY);

  // Event decode
  always_comb begin
    state_t  nx;
    status_e status;
    notice_e notice;
    logic [SleepW-1:0] sleep;

    nx     = st_i;
    status = ST_OK;
    notice = NT_NONE;
    sleep  = '0;

    unique case (opcode_e'(item_i.opcode))
      OP_OPEN: begin
        if (grant != '0) begin
          nx.size_limit = grant;
          nx.txn_id     = '0;
          nx.phase      = PH_ACCEPT;
        end
      end
      OP_CLOSE: begin
        if (st_i.phase != PH_CLOSED) begin
          nx.timer_running = 1'b0;
          nx.size_limit    = '0;
          nx.phase         = PH_CLOSED;
        end
      end
      OP_BEGIN: begin
        if (pending) begin
          nx.backoff_ms = backoff_nxt;
          sleep         = backoff_nxt;
          status        = ST_BUSY;
        end else if (st_i.phase == PH_WRITE || st_i.phase == PH_CLOSED) begin
          status = ST_INVALID;
        end else begin
          nx.phase   = PH_WRITE;
          nx.outcome = OC_OK;
        end
      end
      OP_SEND: begin
        if (pending) begin
          status = ST_BUSY;
        end else if (st_i.phase != PH_WRITE) begin
          status = ST_INVALID;
        end else if (item_i.size_bytes > st_i.size_limit) begin
          status = ST_OVERFLOW;
        end else begin
          nx.txn_id        = st_i.txn_id + IdW'(1);
          nx.phase         = PH_BOTH;
          nx.timer_running = 1'b1;
          nx.timer_count   = cfg_i.ack_timeout_ticks;
        end
      end
      OP_ACK_NACK: begin
        if (awaits_reply && item_i.reply_id == st_i.txn_id) begin
          nx.timer_running = 1'b0;
          if (item_i.is_nack) begin
            nx.outcome = OC_REJECTED;
            if (st_i.phase == PH_REPLY) begin
              nx.phase = PH_ACCEPT;
              notice   = finish_notice(OC_REJECTED);
            end else begin
              nx.phase = PH_XPORT;
            end
          end else if (st_i.phase == PH_BOTH) begin
            nx.phase = PH_XPORT;
          end else begin
            nx.phase = PH_ACCEPT;
            notice   = finish_notice(st_i.outcome);
          end
        end
      end
      OP_XPORT_DONE: begin
        if (!item_i.transport_ok) begin
          nx.backoff_ms    = backoff_nxt;
          sleep            = backoff_nxt;
          nx.timer_running = 1'b0;
          if (st_i.phase == PH_BOTH) begin
            nx.outcome = OC_NOCONN;
            nx.phase   = PH_ACCEPT;
            notice     = finish_notice(OC_NOCONN);
          end
        end else begin
          nx.backoff_ms = '0;
          if (st_i.phase == PH_BOTH) begin
            nx.phase = PH_REPLY;
          end else if (st_i.phase == PH_XPORT) begin
            nx.phase = PH_ACCEPT;
            notice   = finish_notice(st_i.outcome);
          end
        end
      end
      OP_TICK: begin
        if (st_i.timer_running) begin
          if (st_i.timer_count <= TimerW'(1)) begin
            nx.timer_count   = '0;
            nx.timer_running = 1'b0;
            if (awaits_reply) begin
              nx.outcome = OC_TIMEOUT;
              if (st_i.phase == PH_REPLY) begin
                nx.phase = PH_ACCEPT;
                notice   = finish_notice(OC_TIMEOUT);
              end else begin
                nx.phase = PH_XPORT;
              end
            end
          end else begin
            nx.timer_count = st_i.timer_count - TimerW'(1);
          end
        end
      end
      default: begin
        // unused opcode: no effect
      end
    endcase

    st_o             = nx;
    res_o.status     = status;
    res_o.notice     = notice;
    res_o.message_id = nx.txn_id;
    res_o.sleep_ms   = sleep;
    res_o.phase_now  = phase_code(nx.phase);
  end

endmodule

FILE: src/message_outbox_ack_tracker.sv
// Path: an accepted input beat goes to the input register, then to the
// result register, which holds its result beat.
// Throughput: one event per cycle when the result output is not stalled;
// the state updates as an event moves from the input to the result register.
// Reset: phase closed, id, size limit, timer and backoff cleared, outcome ok;
// max_outbox_size = 1024, ack_timeout_ticks = 10000.
// ----------------------------------------------------------------------------
// message_outbox_ack_tracker
// Sender-side tracker for one outstanding message: phase, transaction id,
// ack timer and busy-poll backoff, driven by one event per input beat.
// ----------------------------------------------------------------------------
module message_outbox_ack_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [moat_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [moat_pkg::CfgW-1:0]     cfg_data_i,
  // event input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [moat_pkg::OpW-1:0]      opcode_i,
  input  logic [moat_pkg::SizeW-1:0]    size_bytes_i,
  input  logic [moat_pkg::IdW-1:0]      reply_id_i,
  input  logic                          is_nack_i,
  input  logic                          transport_ok_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [moat_pkg::StatW-1:0]    status_o,
  output logic [moat_pkg::NoticeW-1:0]  notice_o,
  output logic [moat_pkg::IdW-1:0]      message_id_o,
  output logic [moat_pkg::SleepW-1:0]   sleep_ms_o,
  output logic [moat_pkg::PhaseW-1:0]   phase_now_o
);
  import moat_pkg::*;

  cfg_t    cfg_q;
  state_t  st_q, st_d;
  item_t   item_q;
  logic    in_vld_q;
  result_t res_q, res_d;
  logic    out_vld_q;
  logic    advance;

  // Config registers, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_outbox_size   <= MAX_OUTBOX_SIZE_RST;
      cfg_q.ack_timeout_ticks <= ACK_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_OUTBOX_SIZE: cfg_q.max_outbox_size   <= cfg_data_i;
        CFG_ACK_TIMEOUT:     cfg_q.ack_timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage handshake: move the held event into the result register
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Input beat register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.opcode       <= opcode_i;
      item_q.size_bytes   <= size_bytes_i;
      item_q.reply_id     <= reply_id_i;
      item_q.is_nack      <= is_nack_i;
      item_q.transport_ok <= transport_ok_i;
    end
  end

  moat_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // Tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase         <= PH_CLOSED;
      st_q.txn_id        <= '0;
      st_q.size_limit    <= '0;
      st_q.outcome       <= OC_OK;
      st_q.timer_running <= 1'b0;
      st_q.timer_count   <= '0;
      st_q.backoff_ms    <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = res_q.status;
  assign notice_o     = res_q.notice;
  assign message_id_o = res_q.message_id;
  assign sleep_ms_o   = res_q.sleep_ms;
  assign phase_now_o  = res_q.phase_now;

endmodule

FILE: test/message_outbox_ack_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// message_outbox_ack_tracker_test
// Self-checking bench for the outbox ack tracker. A short table of directed
// events walks every opcode and corner of the message life cycle, then
// random event streams run under several register settings. The streams
// mostly follow real message flows, with some noise mixed in. Each result
// beat is checked against its hand-typed value or a cycle-free model of the
// tracker. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module message_outbox_ack_tracker_test;
  import moat_pkg::*;

  localparam logic [OpW-1:0] OP_SPARE    = 3'd7;  // opcode with no function
  localparam int unsigned    QUIET_LIMIT = 2000;
  localparam int unsigned    HOLDOFF_CYC = 100;

  // One result beat as it appears on the output ports
  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [NoticeW-1:0] notice;
    logic [IdW-1:0]     msg_id;
    logic [SleepW-1:0]  sleep;
    logic [PhaseW-1:0]  phase;
  } reply_t;

  // One line of the directed plan: a register write or an event beat
  typedef struct packed {
    logic               is_reg;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgW-1:0]    reg_val;
    item_t              evt;
    logic               typed;
    reply_t             want;
  } plan_row_t;

  // DUT ports
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgW-1:0]     cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [OpW-1:0]      opcode_i       = '0;
  logic [SizeW-1:0]    size_bytes_i   = '0;
  logic [IdW-1:0]      reply_id_i     = '0;
  logic                is_nack_i      = 1'b0;
  logic                transport_ok_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [StatW-1:0]    status_o;
  logic [NoticeW-1:0]  notice_o;
  logic [IdW-1:0]      message_id_o;
  logic [SleepW-1:0]   sleep_ms_o;
  logic [PhaseW-1:0]   phase_now_o;

  // Tracker model state and its copy of the registers
  logic [PhaseW-1:0]   trk_phase    = PC_CLOSED;
  logic [IdW-1:0]      trk_id       = '0;
  logic [SizeW-1:0]    trk_limit    = '0;
  outcome_e            trk_outcome  = OC_OK;
  logic                trk_timer_on = 1'b0;
  logic [TimerW-1:0]   trk_timer    = '0;
  logic [SleepW-1:0]   trk_backoff  = '0;
  logic [CfgW-1:0]     cfg_max      = MAX_OUTBOX_SIZE_RST;
  logic [CfgW-1:0]     cfg_timeout  = ACK_TIMEOUT_RST;

  reply_t              replies_due[$];
  int unsigned         mismatches   = 0;
  int unsigned         beats_seen   = 0;
  int unsigned         burst_left   = 0;
  bit                  sender_eager = 1'b0;
  bit                  holdoff_req  = 1'b0;

  message_outbox_ack_tracker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .size_bytes_i  (size_bytes_i),
    .reply_id_i    (reply_id_i),
    .is_nack_i     (is_nack_i),
    .transport_ok_i(transport_ok_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .notice_o      (notice_o),
    .message_id_o  (message_id_o),
    .sleep_ms_o    (sleep_ms_o),
    .phase_now_o   (phase_now_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  // Busy-poll backoff: 1 ms, then doubling up to the ceiling
  function automatic logic [SleepW-1:0] bump_backoff();
    int unsigned doubled;
    doubled = 2 * trk_backoff;
    if (trk_backoff == '0) begin
      trk_backoff = SleepW'(1);
    end else if (doubled > BACKOFF_CAP) begin
      trk_backoff = BACKOFF_CAP;
    end else begin
      trk_backoff = SleepW'(doubled);
    end
    return trk_backoff;
  endfunction

  // Message done: back to accepting, notice carries the stored outcome
  function automatic logic [NoticeW-1:0] close_out();
    trk_phase = PC_ACCEPT;
    case (trk_outcome)
      OC_OK:       return NT_SENT;
      OC_TIMEOUT:  return NT_TIMEOUT;
      OC_REJECTED: return NT_REJECTED;
      default:     return NT_NOCONN;
    endcase
  endfunction

  // Nack or timeout while a reply is still awaited
  function automatic logic [NoticeW-1:0] reply_lost(outcome_e oc);
    trk_outcome = oc;
    if (trk_phase == PC_REPLY) begin
      return close_out();
    end
    if (trk_phase == PC_BOTH) begin
      trk_phase = PC_XPORT;
    end
    return NT_NONE;
  endfunction

  // Advance the tracker by one event beat and return the result it yields
  function automatic reply_t track_event(input item_t it);
    reply_t           r;
    logic [SizeW-1:0] grant;
    logic             busy_msg;
    logic             wants_reply;
    r           = '0;
    busy_msg    = trk_phase inside {PC_BOTH, PC_REPLY, PC_XPORT};
    wants_reply = (trk_phase == PC_BOTH) || (trk_phase == PC_REPLY);
    case (it.opcode)
      OP_OPEN: begin
        grant = (it.size_bytes > cfg_max) ? cfg_max : it.size_bytes;
        if (grant != '0) begin
          trk_limit = grant;
          trk_id    = '0;
          trk_phase = PC_ACCEPT;
        end
      end
      OP_CLOSE: begin
        if (trk_phase != PC_CLOSED) begin
          trk_timer_on = 1'b0;
          trk_limit    = '0;
          trk_phase    = PC_CLOSED;
        end
      end
      OP_BEGIN: begin
        if (busy_msg) begin
          r.sleep  = bump_backoff();
          r.status = ST_BUSY;
        end else if (trk_phase == PC_WRITE || trk_phase == PC_CLOSED) begin
          r.status = ST_INVALID;
        end else begin
          trk_phase   = PC_WRITE;
          trk_outcome = OC_OK;
        end
      end
      OP_SEND: begin
        if (busy_msg) begin
          r.status = ST_BUSY;
        end else if (trk_phase != PC_WRITE) begin
          r.status = ST_INVALID;
        end else if (it.size_bytes > trk_limit) begin
          r.status = ST_OVERFLOW;
        end else begin
          trk_id       = trk_id + 1'b1;
          trk_phase    = PC_BOTH;
          trk_timer_on = 1'b1;
          trk_timer    = cfg_timeout;
        end
      end
      OP_ACK_NACK: begin
        if (wants_reply && it.reply_id == trk_id) begin
          trk_timer_on = 1'b0;
          if (it.is_nack) begin
            r.notice = reply_lost(OC_REJECTED);
          end else if (trk_phase == PC_BOTH) begin
            trk_phase = PC_XPORT;
          end else begin
            r.notice = close_out();
          end
        end
      end
      OP_XPORT_DONE: begin
        if (!it.transport_ok) begin
          r.sleep      = bump_backoff();
          trk_timer_on = 1'b0;
          if (trk_phase == PC_BOTH) begin
            trk_outcome = OC_NOCONN;
            r.notice    = close_out();
          end
        end else begin
          trk_backoff = '0;
          if (trk_phase == PC_BOTH) begin
            trk_phase = PC_REPLY;
          end else if (trk_phase == PC_XPORT) begin
            r.notice = close_out();
          end
        end
      end
      OP_TICK: begin
        if (trk_timer_on) begin
          if (trk_timer <= 1) begin
            trk_timer    = '0;
            trk_timer_on = 1'b0;
            if (wants_reply) begin
              r.notice = reply_lost(OC_TIMEOUT);
            end
          end else begin
            trk_timer = trk_timer - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.msg_id = trk_id;
    r.phase  = trk_phase;
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic plan_row_t ev(logic [OpW-1:0] op, logic [SizeW-1:0] size,
                                   logic [IdW-1:0] rid, logic nack, logic tok);
    plan_row_t p;
    p                  = '0;
    p.evt.opcode       = op;
    p.evt.size_bytes   = size;
    p.evt.reply_id     = rid;
    p.evt.is_nack      = nack;
    p.evt.transport_ok = tok;
    return p;
  endfunction

  // Same row, with its result typed in by hand
  function automatic plan_row_t chk(plan_row_t p, logic [StatW-1:0] st,
                                    logic [NoticeW-1:0] nt, logic [IdW-1:0] id,
                                    logic [SleepW-1:0] sl, logic [PhaseW-1:0] ph);
    p.typed = 1'b1;
    p.want  = '{status: st, notice: nt, msg_id: id, sleep: sl, phase: ph};
    return p;
  endfunction

  function automatic plan_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    plan_row_t p;
    p         = '0;
    p.is_reg  = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  // Random event, shaped by the model phase so that most beats follow a
  // real message flow; about one in ten is pure noise
  function automatic item_t next_event();
    item_t       it;
    int unsigned pick;
    it.opcode       = OpW'($urandom_range(0, 7));
    it.size_bytes   = SizeW'($urandom);
    it.reply_id     = IdW'($urandom);
    it.is_nack      = 1'($urandom);
    it.transport_ok = 1'($urandom);
    pick            = $urandom_range(0, 99);
    if (pick < 10) begin
      return it;
    end
    case (trk_phase)
      PC_CLOSED: begin
        it.opcode = OP_OPEN;
        if (pick < 80) begin
          it.size_bytes = SizeW'($urandom_range(1, 2000));
        end
      end
      PC_ACCEPT: begin
        if (pick < 75)      it.opcode = OP_BEGIN;
        else if (pick < 93) it.opcode = OP_OPEN;
        else                it.opcode = OP_CLOSE;
      end
      PC_WRITE: begin
        if (pick < 82) begin
          it.opcode = OP_SEND;
          if (pick < 68) begin
            it.size_bytes = SizeW'($urandom_range(0, trk_limit));
          end
        end else if (pick < 92) begin
          it.opcode = OP_BEGIN;
        end else begin
          it.opcode = OP_TICK;
        end
      end
      default: begin
        it.transport_ok = ($urandom_range(0, 5) != 0);
        if (pick < 40) begin
          it.opcode  = OP_ACK_NACK;
          it.is_nack = ($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 4) != 0) begin
            it.reply_id = trk_id;
          end
        end else if (pick < 65) begin
          it.opcode = OP_XPORT_DONE;
        end else if (pick < 85) begin
          it.opcode = OP_TICK;
        end else if (pick < 93) begin
          it.opcode = OP_BEGIN;
        end else if (pick < 97) begin
          it.opcode = OP_SEND;
        end else begin
          it.opcode = OP_CLOSE;
        end
      end
    endcase
    return it;
  endfunction

  // Offer one event beat; the model advances when the beat is taken
  task automatic put_event(input item_t it, input logic typed, input reply_t want);
    reply_t got;
    in_valid_i     <= 1'b1;
    opcode_i       <= it.opcode;
    size_bytes_i   <= it.size_bytes;
    reply_id_i     <= it.reply_id;
    is_nack_i      <= it.is_nack;
    transport_ok_i <= it.transport_ok;
    do @(posedge clk_i); while (!in_ready_o);
    got = track_event(it);
    replies_due.push_back(typed ? want : got);
    // burst bookkeeping: valid stays up inside a burst
    if (sender_eager || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = $urandom_range(0, 10);
    end
  endtask

  // Stop sending and wait until every result beat is back, plus pipe slack
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MAX_OUTBOX_SIZE) cfg_max = val;
    else                            cfg_timeout = val;
  endtask

  initial begin
    plan_row_t        plan[$];
    logic [CfgW-1:0]  max_set[6];
    logic [CfgW-1:0]  tmo_set[6];
    max_set = '{16'd65535, 16'd0, 16'd300, 16'd1, 16'd0, 16'd1024};
    tmo_set = '{16'd1, 16'd3, 16'd6, 16'd65535, 16'd0, 16'd4};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk, reset register values first
    plan.push_back(chk(ev(OP_CLOSE, 0, 0, 0, 0), ST_OK, NT_NONE, 0, 0, PC_CLOSED));
    plan.push_back(chk(ev(OP_BEGIN, 0, 0, 0, 0), ST_INVALID, NT_NONE, 0, 0, PC_CLOSED));
    plan.push_back(chk(ev(OP_OPEN, 0, 0, 0, 0), ST_OK, NT_NONE, 0, 0, PC_CLOSED));
    plan.push_back(chk(ev(OP_OPEN, 16'hFFFF, 0, 0, 0), ST_OK, NT_NONE, 0, 0, PC_ACCEPT));
    plan.push_back(chk(ev(OP_SEND, 10, 0, 0, 0), ST_INVALID, NT_NONE, 0, 0, PC_ACCEPT));
    plan.push_back(chk(ev(OP_BEGIN, 0, 0, 0, 0), ST_OK, NT_NONE, 0, 0, PC_WRITE));
    plan.push_back(chk(ev(OP_BEGIN, 0, 0, 0, 0), ST_INVALID, NT_NONE, 0, 0, PC_WRITE));
    plan.push_back(chk(ev(OP_SEND, 1025, 0, 0, 0), ST_OVERFLOW, NT_NONE, 0, 0, PC_WRITE));
    plan.push_back(chk(ev(OP_SEND, 1024, 0, 0, 0), ST_OK, NT_NONE, 1, 0, PC_BOTH));
    plan.push_back(chk(ev(OP_BEGIN, 0, 0, 0, 0), ST_BUSY, NT_NONE, 1, 1, PC_BOTH));
    plan.push_back(chk(ev(OP_BEGIN, 0, 0, 0, 0), ST_BUSY, NT_NONE, 1, 2, PC_BOTH));
    plan.push_back(chk(ev(OP_SEND, 0, 0, 0, 0), ST_BUSY, NT_NONE, 1, 0, PC_BOTH));
    // reply with a stale id is dropped
    plan.push_back(chk(ev(OP_ACK_NACK, 0, 0, 0, 0), ST_OK, NT_NONE, 1, 0, PC_BOTH));
    plan.push_back(chk(ev(OP_ACK_NACK, 0, 1, 0, 0), ST_OK, NT_NONE, 1, 0, PC_XPORT));
    plan.push_back(chk(ev(OP_XPORT_DONE, 0, 0, 0, 1), ST_OK, NT_SENT, 1, 0, PC_ACCEPT));
    // transport first, then a nack
    plan.push_back(ev(OP_BEGIN, 0, 0, 0, 0));
    plan.push_back(ev(OP_SEND, 0, 0, 0, 0));
    plan.push_back(ev(OP_XPORT_DONE, 0, 0, 0, 1));
    plan.push_back(chk(ev(OP_ACK_NACK, 0, 2, 1, 0), ST_OK, NT_REJECTED, 2, 0, PC_ACCEPT));
    // transport failure while both confirmations are awaited
    plan.push_back(ev(OP_BEGIN, 0, 0, 0, 0));
    plan.push_back(ev(OP_SEND, 5, 0, 0, 0));
    plan.push_back(chk(ev(OP_XPORT_DONE, 0, 0, 0, 0), ST_OK, NT_NOCONN, 3, 1, PC_ACCEPT));
    plan.push_back(chk(ev(OP_SPARE, 16'hFFFF, 8'hFF, 1, 1), ST_OK, NT_NONE, 3, 0, PC_ACCEPT));
    // zero timeout expires on the first tick
    plan.push_back(reg_row(CFG_ACK_TIMEOUT, 16'd0));
    plan.push_back(ev(OP_OPEN, 100, 0, 0, 0));
    plan.push_back(ev(OP_BEGIN, 0, 0, 0, 0));
    plan.push_back(ev(OP_SEND, 100, 0, 0, 0));
    plan.push_back(chk(ev(OP_TICK, 0, 0, 0, 0), ST_OK, NT_NONE, 1, 0, PC_XPORT));
    plan.push_back(chk(ev(OP_XPORT_DONE, 0, 0, 0, 1), ST_OK, NT_TIMEOUT, 1, 0, PC_ACCEPT));
    // zero size ceiling: open grants nothing
    plan.push_back(reg_row(CFG_MAX_OUTBOX_SIZE, 16'd0));
    plan.push_back(ev(OP_OPEN, 500, 0, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else                put_event(plan[i].evt, plan[i].typed, plan[i].want);
    end

    // Random streams under several register settings
    for (int k = 0; k < 6; k++) begin
      if (k == 4) begin
        max_set[k] = CfgW'($urandom_range(1, 4096));
        tmo_set[k] = CfgW'($urandom_range(1, 12));
      end
      write_reg(CFG_MAX_OUTBOX_SIZE, max_set[k]);
      write_reg(CFG_ACK_TIMEOUT, tmo_set[k]);
      sender_eager = ($urandom_range(0, 3) == 0);
      if (k == 0 || $urandom_range(0, 2) == 0) holdoff_req = 1'b1;
      repeat (62) begin
        if ($urandom_range(0, 49) == 0) drain_results();
        put_event(next_event(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ------------------------------------------------------------- receiver

  // Stall pattern of its own, plus an occasional long hold-off that lets
  // the tracker fill up and push back on the event channel
  initial begin
    int unsigned mode;
    int unsigned left;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLDOFF_CYC) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(8, 40);
        end
        left--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // -------------------------------------------------------------- checker

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: beat %0d: %s", $time, beats_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen++;
      if (replies_due.size() == 0) begin
        note_mismatch("result beat with no event outstanding");
      end else begin
        want = replies_due.pop_front();
        check_field("status", 16'(status_o), 16'(want.status));
        check_field("notice", 16'(notice_o), 16'(want.notice));
        check_field("message_id", 16'(message_id_o), 16'(want.msg_id));
        check_field("sleep_ms", 16'(sleep_ms_o), 16'(want.sleep));
        check_field("phase_now", 16'(phase_now_o), 16'(want.phase));
      end
    end
  end

  // Watchdog: ends the run when no channel moves a beat for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
